// ===== sv/crsf_pkg.sv =====
// ============================================================================
// crsf_pkg - shared types and constants of the capture ring controller
// Holds the transfer payloads, the command and event codes, the architectural
// state record and the frame geometry of both line standards.
// ============================================================================
package crsf_pkg;

    // Ring geometry and sentinel byte written into the stamped rows.
    localparam int unsigned RING_BUFFERS  = 3;
    localparam logic [7:0]  SENTINEL_BYTE = 8'h5A;

    // Configuration register indexes and reset values.
    localparam logic [1:0] CFG_HYSTERESIS = 2'd0;
    localparam logic [1:0] CFG_ERASED     = 2'd1;
    localparam logic [5:0] HYST_RESET     = 6'd30;
    localparam logic [7:0] ERASED_RESET   = 8'd22;

    // Frame geometry: arm row sits four fifths down the frame, forced odd.
    localparam int unsigned HEIGHT_525_INT = 480;
    localparam int unsigned HEIGHT_625_INT = 576;
    localparam logic [9:0] HEIGHT_525  = 10'(HEIGHT_525_INT);
    localparam logic [9:0] HEIGHT_625  = 10'(HEIGHT_625_INT);
    localparam logic [9:0] ARM_ROW_525 = 10'(((HEIGHT_525_INT * 4) / 5) | 1);
    localparam logic [9:0] ARM_ROW_625 = 10'(((HEIGHT_625_INT * 4) / 5) | 1);
    localparam logic [9:0] DONE_ROW_525 = 10'(HEIGHT_525_INT - 1);
    localparam logic [9:0] DONE_ROW_625 = 10'(HEIGHT_625_INT - 1);

    typedef enum logic [1:0] {
        CMD_STATUS = 2'd0,
        CMD_PROBE  = 2'd1,
        CMD_STOP   = 2'd2,
        CMD_FORCE  = 2'd3
    } cmd_t;

    typedef enum logic [2:0] {
        EV_INCOMPLETE = 3'd0,
        EV_COMPLETE   = 3'd1,
        EV_STANDARD   = 3'd2,
        EV_HELD       = 3'd3,
        EV_STOPPED    = 3'd4
    } event_t;

    typedef struct packed {
        cmd_t       command;
        logic       no_signal;
        logic       vertical_lock;
        logic       lines_625;
        logic [7:0] probe_pixel;
        logic       probe_last;
        logic       forced_standard;
    } in_item_t;

    typedef struct packed {
        event_t      event_res;
        logic [1:0]  write_buffer;
        logic [1:0]  safe_buffer;
        logic        safe_valid;
        logic        standard;
        logic [9:0]  frame_height;
        logic        stamp_request;
        logic [9:0]  arm_row;
        logic [9:0]  done_row;
        logic [5:0]  agree_count;
        logic [31:0] frame_count;
        logic [31:0] switch_count;
    } out_item_t;

    typedef struct packed {
        logic [1:0]  write_index;
        logic [1:0]  done_index;
        logic        done_valid;
        logic [1:0]  safe_index;
        logic        safe_present;
        logic        standard;
        logic [5:0]  agreement;
        logic [7:0]  match_count;
        logic [31:0] frames_done;
        logic [31:0] switches_done;
    } crsf_state_t;

    localparam crsf_state_t STATE_RESET = '{
        write_index:   2'd0,
        done_index:    2'd0,
        done_valid:    1'b0,
        safe_index:    2'd0,
        safe_present:  1'b0,
        standard:      1'b0,
        agreement:     6'd0,
        match_count:   8'd0,
        frames_done:   32'd0,
        switches_done: 32'd0
    };

endpackage

// ===== sv/crsf_step.sv =====
// ============================================================================
// crsf_step - next-state and result logic for one item
// Applies one registered item to the controller state and forms the result
// transfer from the updated state.
// ============================================================================
module crsf_step (
    input  crsf_pkg::in_item_t    item,
    input  crsf_pkg::crsf_state_t state_cur,
    input  logic [5:0]            hysteresis_limit,
    input  logic [7:0]            erased_limit,
    output crsf_pkg::crsf_state_t state_next,
    output crsf_pkg::out_item_t   result,
    output logic                  result_valid
);
    import crsf_pkg::*;

    logic [5:0] agree_inc;
    logic [7:0] match_inc;
    logic [1:0] write_inc;
    event_t     ev;
    logic       stamp;

    assign agree_inc = state_cur.agreement + 6'd1;
    assign match_inc = state_cur.match_count +
                       {7'd0, (item.probe_pixel == SENTINEL_BYTE)};
    assign write_inc = (state_cur.write_index == 2'(RING_BUFFERS - 1)) ?
                       2'd0 : state_cur.write_index + 2'd1;

    always_comb begin
        state_next   = state_cur;
        result_valid = 1'b1;
        ev           = EV_HELD;
        stamp        = 1'b0;
        unique case (item.command)
            CMD_STATUS: begin
                if (item.no_signal) begin
                    state_next.agreement = 6'd0;
                end else if (!item.vertical_lock || item.lines_625 == state_cur.standard) begin
                    if (state_cur.agreement != 6'd0) begin
                        state_next.agreement = state_cur.agreement - 6'd1;
                    end
                end else if (agree_inc >= hysteresis_limit) begin
                    // Enough disagreeing samples: follow the decoder and reset the ring.
                    state_next.agreement     = 6'd0;
                    state_next.switches_done = state_cur.switches_done + 32'd1;
                    state_next.standard      = item.lines_625;
                    state_next.write_index   = 2'd0;
                    state_next.done_valid    = 1'b0;
                    state_next.safe_present  = 1'b0;
                    state_next.match_count   = 8'd0;
                    ev    = EV_STANDARD;
                    stamp = 1'b1;
                end else begin
                    state_next.agreement = agree_inc;
                end
            end
            CMD_PROBE: begin
                if (!item.probe_last) begin
                    state_next.match_count = match_inc;
                    result_valid = 1'b0;
                end else begin
                    state_next.match_count = 8'd0;
                    if (match_inc < erased_limit) begin
                        // Sentinel row overwritten: the frame landed, rotate the ring.
                        state_next.safe_index   = state_cur.done_index;
                        state_next.safe_present = state_cur.done_valid;
                        state_next.done_index   = state_cur.write_index;
                        state_next.done_valid   = 1'b1;
                        state_next.write_index  = write_inc;
                        state_next.frames_done  = state_cur.frames_done + 32'd1;
                        ev    = EV_COMPLETE;
                        stamp = 1'b1;
                    end else begin
                        ev = EV_INCOMPLETE;
                    end
                end
            end
            CMD_STOP: begin
                state_next.done_valid   = 1'b0;
                state_next.safe_present = 1'b0;
                state_next.match_count  = 8'd0;
                ev = EV_STOPPED;
            end
            CMD_FORCE: begin
                state_next.standard     = item.forced_standard;
                state_next.write_index  = 2'd0;
                state_next.done_valid   = 1'b0;
                state_next.safe_present = 1'b0;
                state_next.match_count  = 8'd0;
                ev    = EV_STANDARD;
                stamp = 1'b1;
            end
            default: begin
                result_valid = 1'b0;
            end
        endcase
    end

    always_comb begin
        result.event_res     = ev;
        result.write_buffer  = state_next.write_index;
        result.safe_buffer   = state_next.safe_present ? state_next.safe_index : 2'd0;
        result.safe_valid    = state_next.safe_present;
        result.standard      = state_next.standard;
        result.frame_height  = state_next.standard ? HEIGHT_625 : HEIGHT_525;
        result.stamp_request = stamp;
        result.arm_row       = state_next.standard ? ARM_ROW_625 : ARM_ROW_525;
        result.done_row      = state_next.standard ? DONE_ROW_625 : DONE_ROW_525;
        result.agree_count   = state_next.agreement;
        result.frame_count   = state_next.frames_done;
        result.switch_count  = state_next.switches_done;
    end

endmodule

// ===== sv/capture_ring_and_standard_follow.sv =====
// ============================================================================
// capture_ring_and_standard_follow - video capture ring and standard follower
// Rotates a three-buffer capture ring on sentinel probe results and follows
// the decoder line standard through a leaky agreement counter.
// ============================================================================
// The item is registered in the input stage and its result in the result stage,
// whose valid register drives m_valid.
// Throughput: one item per cycle unless a result stalls; the state update loop
// through crsf_step is combinational, so each item sees its predecessor's effects.
// A stalled result holds every item in the input stage, results or not.
// Reset: synchronous, active low; clears the ring, standard (525-line),
// counters and both handshake stages, and reloads both limit registers.
module capture_ring_and_standard_follow (
    input  logic                aclk,
    input  logic                aresetn,
    // Input item channel.
    input  logic                s_valid,
    output logic                s_ready,
    input  crsf_pkg::in_item_t  s_item,
    // Result channel.
    output logic                m_valid,
    input  logic                m_ready,
    output crsf_pkg::out_item_t m_item,
    // Configuration write channel.
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [1:0]          cfg_index,
    input  logic [7:0]          cfg_data
);
    import crsf_pkg::*;

    // Input stage: one item waits here while its state update is computed.
    logic        in_vld_reg;
    in_item_t    in_item_reg;

    // Architectural state of the ring and the standard follower.
    crsf_state_t state_reg;
    crsf_state_t state_next;

    // Result stage.
    logic        out_vld_reg;
    out_item_t   out_item_reg;

    // Configuration registers.
    logic [5:0]  hyst_reg;
    logic [7:0]  erased_reg;

    out_item_t   step_result;
    logic        step_valid;
    logic        advance;

    // The input stage drains whenever the result stage can take a transfer.
    // Every item, including probe pixels that give no result, waits while a
    // result is stalled, so the pending result is never disturbed.
    assign advance   = in_vld_reg && (!out_vld_reg || m_ready);
    assign s_ready   = !in_vld_reg || advance;
    assign cfg_ready = 1'b1;
    assign m_valid   = out_vld_reg;
    assign m_item    = out_item_reg;

    crsf_step u_step (
        .item             (in_item_reg),
        .state_cur        (state_reg),
        .hysteresis_limit (hyst_reg),
        .erased_limit     (erased_reg),
        .state_next       (state_next),
        .result           (step_result),
        .result_valid     (step_valid)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_vld_reg <= 1'b0;
        end else if (s_ready) begin
            in_vld_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_item_reg <= s_item;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= STATE_RESET;
        end else if (advance) begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_vld_reg <= 1'b0;
        end else if (advance && step_valid) begin
            out_vld_reg <= 1'b1;
        end else if (m_ready) begin
            out_vld_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance && step_valid) begin
            out_item_reg <= step_result;
        end
    end

    // User writes limits only while idle; not enforced. Other indexes are ignored.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hyst_reg   <= HYST_RESET;
            erased_reg <= ERASED_RESET;
        end else if (cfg_valid && cfg_ready) begin
            if (cfg_index == CFG_HYSTERESIS) begin
                hyst_reg <= cfg_data[5:0];
            end else if (cfg_index == CFG_ERASED) begin
                erased_reg <= cfg_data;
            end
        end
    end

    // The three ring roles never share a buffer while they are valid.
    assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg.safe_present |->
            (state_reg.safe_index != state_reg.write_index) &&
            (!state_reg.done_valid || state_reg.safe_index != state_reg.done_index))
        else $error("safe buffer aliases another ring role");

    assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg.done_valid |-> state_reg.done_index != state_reg.write_index)
        else $error("done buffer aliases the write buffer");

    // State only moves when an item leaves the input stage.
    assert property (@(posedge aclk) disable iff (!aresetn)
        !advance |=> $stable(state_reg))
        else $error("state changed without an item");

    // A pending result is only dropped by a completed transfer.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (out_vld_reg && !m_ready) |=> out_vld_reg && $stable(out_item_reg))
        else $error("stalled result lost or overwritten");

endmodule

// ===== tb/capture_ring_and_standard_follow_test.sv =====
`timescale 1ns / 100ps
// ============================================================================
// capture_ring_and_standard_follow_test - self-checking bench of the ring
// Drives probe rows, decoder status runs, stops and forced standards through
// the item channel under several limit settings and idling patterns. It tracks
// the ring and the standard follower itself and checks each result against it.
// ============================================================================
module capture_ring_and_standard_follow_test;

    import crsf_pkg::*;

    // Run length guard and the settle time after the last expected result.
    // Probe pixels that are not the last of a row give no result, so the settle
    // time follows to let them pass through.
    localparam int LIMIT_CYCLES  = 400000;
    localparam int SETTLE_CYCLES = 8;

    // ------------------------------------------------------------------------
    // Tracker of the capture ring: holds its own copy of the limits and the
    // ring, follower and counter state, predicts the result of each accepted
    // item and compares arriving results with the oldest prediction.
    // ------------------------------------------------------------------------
    class capture_ring_tracker;
        logic [5:0]  hyst_limit;
        logic [7:0]  erase_limit;
        logic [1:0]  write_index;
        logic [1:0]  done_index;
        logic        done_valid;
        logic [1:0]  safe_index;
        logic        safe_present;
        logic        standard;
        logic [5:0]  agreement;
        logic [7:0]  match_count;
        logic [31:0] frames;
        logic [31:0] switches;
        out_item_t   awaited[$];
        int          failures;
        int          accepted;
        int          checked;
        int          completions;
        int          auto_switches;

        function new();
            hyst_limit    = 6'd30;
            erase_limit   = 8'd22;
            write_index   = '0;
            done_index    = '0;
            done_valid    = 1'b0;
            safe_index    = '0;
            safe_present  = 1'b0;
            standard      = 1'b0;
            agreement     = '0;
            match_count   = '0;
            frames        = '0;
            switches      = '0;
            failures      = 0;
            accepted      = 0;
            checked       = 0;
            completions   = 0;
            auto_switches = 0;
        endfunction

        function int outstanding();
            return awaited.size();
        endfunction

        function void restart_ring(logic std);
            standard     = std;
            write_index  = '0;
            done_valid   = 1'b0;
            safe_present = 1'b0;
            match_count  = '0;
        endfunction

        function void queue_result(event_t ev, logic stamp);
            out_item_t   r;
            logic [9:0]  h;
            int unsigned hi;
            h  = standard ? HEIGHT_625 : HEIGHT_525;
            hi = h;
            r.event_res     = ev;
            r.write_buffer  = write_index;
            r.safe_buffer   = safe_present ? safe_index : 2'd0;
            r.safe_valid    = safe_present;
            r.standard      = standard;
            r.frame_height  = h;
            r.stamp_request = stamp;
            r.arm_row       = 10'(((hi * 4) / 5) | 1);
            r.done_row      = h - 10'd1;
            r.agree_count   = agreement;
            r.frame_count   = frames;
            r.switch_count  = switches;
            awaited.push_back(r);
        endfunction

        function void absorb_item(in_item_t it);
            logic switched;
            switched = 1'b0;
            accepted++;
            case (it.command)
                CMD_STATUS: begin
                    if (it.no_signal) begin
                        agreement = '0;
                    end else if (!it.vertical_lock || it.lines_625 == standard) begin
                        if (agreement != 0) agreement = agreement - 6'd1;
                    end else begin
                        agreement = agreement + 6'd1;
                        if (agreement >= hyst_limit) begin
                            agreement = '0;
                            switches  = switches + 32'd1;
                            auto_switches++;
                            restart_ring(it.lines_625);
                            switched = 1'b1;
                        end
                    end
                    if (switched) queue_result(EV_STANDARD, 1'b1);
                    else queue_result(EV_HELD, 1'b0);
                end
                CMD_PROBE: begin
                    if (it.probe_pixel == SENTINEL_BYTE) match_count = match_count + 8'd1;
                    if (it.probe_last) begin
                        if (match_count < erase_limit) begin
                            safe_index   = done_index;
                            safe_present = done_valid;
                            done_index   = write_index;
                            done_valid   = 1'b1;
                            write_index  = 2'((write_index + 1) % RING_BUFFERS);
                            frames       = frames + 32'd1;
                            completions++;
                            match_count  = '0;
                            queue_result(EV_COMPLETE, 1'b1);
                        end else begin
                            match_count = '0;
                            queue_result(EV_INCOMPLETE, 1'b0);
                        end
                    end
                end
                CMD_STOP: begin
                    done_valid   = 1'b0;
                    safe_present = 1'b0;
                    match_count  = '0;
                    queue_result(EV_STOPPED, 1'b0);
                end
                default: begin
                    restart_ring(it.forced_standard);
                    queue_result(EV_STANDARD, 1'b1);
                end
            endcase
        endfunction

        function void check_field(string field, logic [31:0] want, logic [31:0] got);
            if (want !== got) begin
                $error("%s: expected %0d, actual %0d", field, want, got);
                failures++;
            end
        endfunction

        function void match_result(out_item_t got);
            out_item_t want;
            if (awaited.size() == 0) begin
                $error("result transfer with nothing pending: event_res %0d", got.event_res);
                failures++;
            end else begin
                want = awaited.pop_front();
                checked++;
                check_field("event_res", want.event_res, got.event_res);
                check_field("write_buffer", want.write_buffer, got.write_buffer);
                check_field("safe_buffer", want.safe_buffer, got.safe_buffer);
                check_field("safe_valid", want.safe_valid, got.safe_valid);
                check_field("standard", want.standard, got.standard);
                check_field("frame_height", want.frame_height, got.frame_height);
                check_field("stamp_request", want.stamp_request, got.stamp_request);
                check_field("arm_row", want.arm_row, got.arm_row);
                check_field("done_row", want.done_row, got.done_row);
                check_field("agree_count", want.agree_count, got.agree_count);
                check_field("frame_count", want.frame_count, got.frame_count);
                check_field("switch_count", want.switch_count, got.switch_count);
            end
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // Clock, reset and the block's inputs. Every input holds a known value
    // from time zero; after that all of them change only by nonblocking
    // assignment right after a rising edge.
    // ------------------------------------------------------------------------
    logic      aclk      = 1'b0;
    logic      aresetn   = 1'b0;
    logic      s_valid   = 1'b0;
    logic      s_ready;
    in_item_t  s_item    = '0;
    logic      m_valid;
    logic      m_ready   = 1'b0;
    out_item_t m_item;
    logic      cfg_valid = 1'b0;
    logic      cfg_ready;
    logic [1:0] cfg_index = CFG_HYSTERESIS;
    logic [7:0] cfg_data  = '0;

    // Idling pattern of the current phase, in percent of cycles.
    int sender_idle_pct   = 0;
    int receiver_stall_pct = 0;
    int cycle_count       = 0;
    int settings_used     = 1;

    capture_ring_tracker book = new();

    always #4 aclk = ~aclk;

    capture_ring_and_standard_follow dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_item    (s_item),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_item    (m_item),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // Run guard: a hung handshake or a lost result ends the run here.
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > LIMIT_CYCLES) begin
            $display("capture_ring_and_standard_follow_test NOT OK");
            $finish;
        end
    end

    // Result side. Values are sampled at the edge before the block's own
    // updates land, so a transfer seen here is the one that the edge moved.
    // Ready is redrawn every cycle, independent of valid.
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) book.match_result(m_item);
        m_ready <= ($urandom_range(99) >= receiver_stall_pct);
    end

    // ------------------------------------------------------------------------
    // Item builders. Fields that a command does not look at are left random
    // so that every bit of the payload moves.
    // ------------------------------------------------------------------------
    function automatic in_item_t random_item();
        logic [31:0] word;
        word = $urandom;
        return in_item_t'(word[$bits(in_item_t)-1:0]);
    endfunction

    function automatic in_item_t probe_item(logic [7:0] pix, logic last);
        in_item_t it;
        it = random_item();
        it.command     = CMD_PROBE;
        it.probe_pixel = pix;
        it.probe_last  = last;
        return it;
    endfunction

    function automatic in_item_t status_item(logic nosig, logic vlock, logic l625);
        in_item_t it;
        it = random_item();
        it.command       = CMD_STATUS;
        it.no_signal     = nosig;
        it.vertical_lock = vlock;
        it.lines_625     = l625;
        return it;
    endfunction

    function automatic in_item_t command_item(cmd_t cmd, logic forced);
        in_item_t it;
        it = random_item();
        it.command         = cmd;
        it.forced_standard = forced;
        return it;
    endfunction

    // ------------------------------------------------------------------------
    // Sender. Valid stays high from one item to the next unless an idle gap
    // is drawn, so it is never lowered and raised in the same time step. The
    // tracker learns of an item at the edge that accepts it, which keeps its
    // state current for the generator that builds the next item.
    // ------------------------------------------------------------------------
    task automatic send_item(input in_item_t it);
        int gap;
        gap = 0;
        while ($urandom_range(99) < sender_idle_pct) gap++;
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_item  <= it;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        book.absorb_item(it);
    endtask

    // Holds the sender off until every predicted result has arrived, then
    // lets the block finish any probe pixel that gave no result.
    task automatic drain_results();
        s_valid <= 1'b0;
        while (book.outstanding() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // Writes both limit registers back to back; only called while idle.
    task automatic program_limits(input logic [5:0] hyst, input logic [7:0] erased);
        cfg_valid <= 1'b1;
        cfg_index <= CFG_HYSTERESIS;
        cfg_data  <= {2'b00, hyst};
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        book.hyst_limit = hyst;
        cfg_index <= CFG_ERASED;
        cfg_data  <= erased;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        book.erase_limit = erased;
        cfg_valid <= 1'b0;
        settings_used++;
    endtask

    // One probed row: len pixels, a share of them sentinel bytes, the final
    // one marked last. Other pixels are random and may hit the sentinel too.
    task automatic send_row(input int len, input int sentinel_pct);
        logic [7:0] pix;
        for (int i = 0; i < len; i++) begin
            pix = ($urandom_range(99) < sentinel_pct) ? SENTINEL_BYTE : 8'($urandom);
            send_item(probe_item(pix, i == len - 1));
        end
    endtask

    // A run of decoder status samples that mostly disagree with the current
    // standard under vertical lock, so the agreement counter climbs toward
    // the limit; a few samples are noise that hold or clear it.
    task automatic send_status_run(input int len);
        for (int i = 0; i < len; i++) begin
            if ($urandom_range(99) < 12) send_item(status_item(1'($urandom), 1'($urandom),
                                                                1'($urandom)));
            else send_item(status_item(1'b0, 1'b1, ~book.standard));
        end
    endtask

    task automatic random_burst();
        int pick;
        int len;
        pick = $urandom_range(99);
        len  = ($urandom_range(9) == 0) ? $urandom_range(20, 40) : $urandom_range(1, 10);
        if (pick < 45) send_row(len, $urandom_range(100));
        else if (pick < 75) send_status_run($urandom_range(1, book.hyst_limit + 4));
        else if (pick < 85) send_item(command_item(CMD_STOP, 1'($urandom)));
        else if (pick < 93) send_item(command_item(CMD_FORCE, 1'($urandom)));
        else send_item(random_item());
    endtask

    task automatic run_random(input int count);
        int start;
        start = book.accepted;
        while (book.accepted - start < count) random_burst();
    endtask

    // ------------------------------------------------------------------------
    // Main sequence.
    // ------------------------------------------------------------------------
    initial begin
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed part under the reset limits, no idling. A short row with
        // the extreme pixel values completes the first frame; further
        // one-pixel rows walk the write buffer around the ring so the safe
        // buffer appears and wraps.
        send_item(probe_item(8'h00, 1'b0));
        send_item(probe_item(8'hFF, 1'b0));
        send_item(probe_item(SENTINEL_BYTE, 1'b0));
        send_item(probe_item(SENTINEL_BYTE, 1'b1));
        send_item(probe_item(SENTINEL_BYTE, 1'b1));
        send_item(probe_item(8'h5B, 1'b1));
        send_item(probe_item(8'h59, 1'b1));
        // Status: no signal, no vertical lock, agreeing, then disagreeing
        // samples that raise the counter and an agreeing one that leaks it.
        send_item(status_item(1'b1, 1'b1, 1'b1));
        send_item(status_item(1'b0, 1'b0, 1'b1));
        send_item(status_item(1'b0, 1'b1, 1'b0));
        send_item(status_item(1'b0, 1'b1, 1'b1));
        send_item(status_item(1'b0, 1'b1, 1'b1));
        send_item(status_item(1'b0, 1'b1, 1'b1));
        send_item(status_item(1'b0, 1'b1, 1'b0));
        send_item(status_item(1'b1, 1'b0, 1'b0));
        // Stop drops done and safe buffers; the next frame starts fresh.
        send_item(command_item(CMD_STOP, 1'b0));
        send_item(probe_item(SENTINEL_BYTE, 1'b1));
        send_item(probe_item(8'hA5, 1'b1));
        // Forced standards, repeated and back, reset the ring each time.
        send_item(command_item(CMD_FORCE, 1'b1));
        send_item(probe_item(8'h3C, 1'b1));
        send_item(command_item(CMD_FORCE, 1'b1));
        send_item(command_item(CMD_FORCE, 1'b0));
        drain_results();

        // Reset limits, random traffic without idling.
        run_random(50);
        drain_results();

        // A hysteresis of one and an erased limit of zero: every disagreeing
        // sample switches and no frame can complete. Sender mostly idle.
        program_limits(6'd1, 8'd0);
        sender_idle_pct = 70;
        run_random(50);
        drain_results();

        // Highest hysteresis, erased limit 128, receiver stalling. A row of 258
        // sentinels wraps the 8-bit match count back below the erased limit.
        program_limits(6'd63, 8'd128);
        sender_idle_pct    = 0;
        receiver_stall_pct = 70;
        send_row(258, 100);
        run_random(40);
        drain_results();

        // Random limits, both sides idling now and then.
        program_limits(6'($urandom_range(1, 63)), 8'($urandom_range(0, 128)));
        sender_idle_pct    = 18;
        receiver_stall_pct = 18;
        run_random(40);
        drain_results();

        // Small limits. The sender holds off halfway until everything has
        // arrived, then both sides run flat out.
        program_limits(6'd5, 8'd4);
        sender_idle_pct    = 70;
        receiver_stall_pct = 70;
        run_random(20);
        drain_results();
        sender_idle_pct    = 0;
        receiver_stall_pct = 0;
        run_random(20);
        drain_results();

        $display("Covered %0d input transfers and %0d checked results under %0d limit settings,",
                 book.accepted, book.checked, settings_used);
        $display("with %0d completed frames and %0d automatic standard switches.",
                 book.completions, book.auto_switches);
        if (book.failures == 0) begin
            $display("capture_ring_and_standard_follow_test OK");
        end else begin
            $display("capture_ring_and_standard_follow_test NOT OK");
        end
        $finish;
    end

endmodule
